FILE: rtl/kvmt_pkg.sv
package kvmt_pkg;

	localparam int unsigned ENTRIES_DEF = 64;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned VAL_W       = 31;
	localparam int unsigned FUNC_W      = 2;
	localparam int unsigned WORD_W      = 1 + KEY_W + VAL_W;

	localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// one memory word: valid mark, key, value
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

endpackage

FILE: rtl/kvmt_req_if.sv
interface kvmt_req_if
	import kvmt_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic signed [KEY_W-1:0] lookup_key;
	logic [VAL_W-1:0]        new_value;

	modport source (output valid, output func, output lookup_key, output new_value,
		input ready);
	modport sink (input valid, input func, input lookup_key, input new_value,
		output ready);
endinterface

FILE: rtl/kvmt_rsp_if.sv
interface kvmt_rsp_if
	import kvmt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             found;
	logic [VAL_W-1:0] read_value;
	logic             table_full;

	modport source (output valid, output found, output read_value, output table_full,
		input ready);
	modport sink (input valid, input found, input read_value, input table_full,
		output ready);
endinterface

FILE: rtl/key_value_map_table_unit.sv
// Bounded key/value table with put, get and remove requests.
//
// req carries one request word: func (put, get, remove), lookup_key and
// new_value. rsp returns exactly one word per request: found, read_value
// (the stored value on a get hit, else 0) and table_full (a put of a new key
// was dropped because every entry is valid).
//
// All entries sit in one synchronous memory of ENTRIES words, each holding a
// valid mark, key and value. A request reads every word in turn, one a cycle,
// noting the matching entry and the lowest free one, then writes back at most
// one word. A request passes through the scan, drain and finish states before
// its response register is loaded, and no new request is taken until the
// write-back of the last one is done.
//
// After reset the block runs a clearing pass over every memory word and holds
// req.ready low until it ends. The response sits in an output register: while
// the receiver stalls, the next request is still taken and searched, and its
// write-back waits until the output register frees up.
module key_value_map_table_unit
	import kvmt_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kvmt_req_if.sink  req,
	kvmt_rsp_if.source rsp
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t state_q;
	logic [IDX_W-1:0] cnt_q;

	// request held for the whole search
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;

	// search results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// memory and its read pipeline
	entry_t           mem [ENTRIES];
	entry_t           rd_s1;
	logic             rv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;

	logic             out_valid_q;
	logic             found_q;
	logic [VAL_W-1:0] read_value_q;
	logic             table_full_q;

	logic req_acc;
	logic out_free;
	logic finish;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign finish    = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_acc) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q <= req.func;
			key_q  <= req.lookup_key;
			val_q  <= req.new_value;
		end
	end

	// write-back word, or the clearing write after reset
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q;
		mem_wd = '{valid: 1'b1, key: key_q, value: val_q};
		if (state_q == ST_CLEAR) begin
			mem_we       = 1'b1;
			mem_wd.valid = 1'b0;
		end else if (finish) begin
			case (func_q)
				FUNC_PUT: begin
					if (hit_q) begin
						mem_we = 1'b1;
						mem_wa = hit_idx_q;
					end else if (free_q) begin
						mem_we = 1'b1;
						mem_wa = free_idx_q;
					end
				end
				FUNC_REMOVE: begin
					mem_we       = hit_q;
					mem_wa       = hit_idx_q;
					mem_wd.valid = 1'b0;
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1  <= mem[cnt_q];
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1  <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SCAN);
			if (req_acc) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rv_s1) begin
				if (rd_s1.valid && rd_s1.key == key_q) hit_q <= 1'b1;
				// keep the lowest free entry
				if (!rd_s1.valid && !free_q) free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1 && rd_s1.valid && rd_s1.key == key_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= rd_s1.value;
		end
		if (rv_s1 && !rd_s1.valid && !free_q) free_idx_q <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			found_q      <= hit_q && (func_q == FUNC_PUT || func_q == FUNC_GET ||
				func_q == FUNC_REMOVE);
			read_value_q <= (func_q == FUNC_GET && hit_q) ? hit_val_q : '0;
			table_full_q <= (func_q == FUNC_PUT) && !hit_q && !free_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;
	assign rsp.table_full = table_full_q;

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !mem_we)
		else $error("memory written during search");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response loaded outside write-back");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.table_full))
		else $error("found and table_full both set");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.read_value != '0) |-> rsp.found)
		else $error("value returned without a hit");

	a_full_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> $past(cnt_q) == LAST_IDX)
		else $error("search ended before the last entry");

endmodule

FILE: bench/kvmt_checker.sv
`timescale 1ns / 100ps

module kvmt_checker
	import kvmt_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kvmt_req_if         req,
	kvmt_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	localparam int unsigned REPORT_CAP = 100;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             table_full;
	} answer_t;

	logic             slot_used [ENTRIES];
	logic [KEY_W-1:0] slot_key  [ENTRIES];
	logic [VAL_W-1:0] slot_val  [ENTRIES];
	answer_t          answer_q  [$];
	int unsigned      report_count = 0;

	// Search the table, update it and return the answer for one request word.
	function automatic answer_t apply_request(input logic [FUNC_W-1:0] func,
		input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
		answer_t ans;
		int      hit;
		int      free;
		ans  = '0;
		hit  = -1;
		free = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && slot_key[i] == key && hit < 0)
				hit = i;
			if (!slot_used[i] && free < 0)
				free = i;
		end
		case (func)
			FUNC_PUT: begin
				if (hit >= 0) begin
					slot_val[hit] = value;
					ans.found = 1'b1;
				end else if (free >= 0) begin
					slot_used[free] = 1'b1;
					slot_key[free]  = key;
					slot_val[free]  = value;
				end else begin
					ans.table_full = 1'b1;
				end
			end
			FUNC_GET: begin
				if (hit >= 0) begin
					ans.found      = 1'b1;
					ans.read_value = slot_val[hit];
				end
			end
			FUNC_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					ans.found      = 1'b1;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	function automatic int unsigned field_differs(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want === got)
			return 0;
		if (report_count < REPORT_CAP) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			report_count++;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_words
		answer_t     want;
		int unsigned fails;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
			answer_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			fails = fail_count;
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					fails++;
					if (report_count < REPORT_CAP) begin
						$display("%0t: response word with none expected, actual %0h %0h %0h",
							$time, rsp.found, rsp.read_value, rsp.table_full);
						report_count++;
					end
				end else begin
					want = answer_q.pop_front();
					fails += field_differs("found", 32'(want.found), 32'(rsp.found));
					fails += field_differs("read_value", 32'(want.read_value),
						32'(rsp.read_value));
					fails += field_differs("table_full", 32'(want.table_full),
						32'(rsp.table_full));
				end
			end
			if (req.valid && req.ready)
				answer_q.push_back(apply_request(req.func, req.lookup_key, req.new_value));
			fail_count  <= fails;
			outstanding <= answer_q.size();
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import kvmt_pkg::*;

	localparam int unsigned       ENTRIES     = ENTRIES_DEF;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned       ITEM_TARGET = 850;
	localparam int unsigned       CYCLE_LIMIT = 1_500_000;
	localparam int unsigned       KEY_POOL    = 96;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned burst_left  = 1;
	int unsigned ready_hold  = 0;
	int unsigned sent        = 0;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	kvmt_req_if req ();
	kvmt_rsp_if rsp ();

	key_value_map_table_unit #(.ENTRIES(ENTRIES)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	kvmt_checker #(.ENTRIES(ENTRIES)) watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: long open stretches mixed with short, medium and long stalls.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			case ($urandom_range(0, 5))
				0, 1, 2: begin
					rsp.ready  <= 1'b1;
					ready_hold <= $urandom_range(0, 300);
				end
				3: begin
					rsp.ready  <= 1'b0;
					ready_hold <= $urandom_range(0, 4);
				end
				4: begin
					rsp.ready  <= 1'b0;
					ready_hold <= $urandom_range(5, 70);
				end
				default: begin
					rsp.ready  <= 1'b0;
					ready_hold <= $urandom_range(71, 140);
				end
			endcase
		end
	end

	// After each accepted word, maybe end the burst and idle for a while.
	task automatic pace();
		int unsigned gap;
		gap = 0;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 3);
				2: gap = $urandom_range(4, 30);
				default: gap = $urandom_range(31, 90);
			endcase
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_word(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		req.valid      <= 1'b1;
		req.func       <= func;
		req.lookup_key <= key;
		req.new_value  <= value;
		do @(posedge clk); while (!req.ready);
		sent++;
		pace();
	endtask

	// Hold off until every response word is back.
	task automatic await_drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		logic [VAL_W-1:0] value;
		value = VAL_W'($urandom);
		case ($urandom_range(0, 7))
			0: value = '0;
			1: value = '1;
			default: ;
		endcase
		return value;
	endfunction

	function automatic logic [KEY_W-1:0] pool_key();
		return key_pool[$urandom_range(0, KEY_POOL - 1)];
	endfunction

	// Swap a few pool keys; some differ from another pool key in one bit only.
	task automatic refresh_pool(input int unsigned count);
		int unsigned idx;
		repeat (count) begin
			idx = $urandom_range(0, KEY_POOL - 1);
			if ($urandom_range(0, 3) == 0)
				key_pool[idx] = pool_key() ^ (32'd1 << $urandom_range(0, KEY_W - 1));
			else
				key_pool[idx] = $urandom;
		end
	endtask

	// One round in a single mode: fill, mixed, drain or noise.
	task automatic run_round();
		int unsigned       mode;
		int unsigned       count;
		int unsigned       pick;
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		mode  = $urandom_range(0, 9);
		count = $urandom_range(15, 60);
		refresh_pool($urandom_range(0, 4));
		repeat (count) begin
			pick = $urandom_range(0, 99);
			key  = pool_key();
			if (mode < 3)
				func = pick < 80 ? FUNC_PUT : (pick < 95 ? FUNC_GET : FUNC_REMOVE);
			else if (mode < 7)
				func = pick < 34 ? FUNC_PUT : (pick < 67 ? FUNC_GET : FUNC_REMOVE);
			else if (mode < 9)
				func = pick < 15 ? FUNC_PUT : (pick < 35 ? FUNC_GET : FUNC_REMOVE);
			else begin
				func = FUNC_W'($urandom_range(0, 3));
				if (pick < 50)
					key = $urandom;
			end
			send_word(func, key, rand_value());
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.func       <= FUNC_PUT;
		req.lookup_key <= '0;
		req.new_value  <= '0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'hffff_ffff;
		key_pool[3] = 32'h0000_0000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: misses, then puts of new keys and gets of them
		send_word(FUNC_GET, 32'h8000_0000, '1);
		send_word(FUNC_REMOVE, 32'h0000_0000, '0);
		send_word(FUNC_PUT, 32'h8000_0000, 31'h7fff_ffff);
		send_word(FUNC_PUT, 32'h7fff_ffff, 31'h0000_0000);
		send_word(FUNC_PUT, 32'hffff_ffff, 31'h5555_5555);
		send_word(FUNC_PUT, 32'h0000_0000, 31'h2aaa_aaaa);
		send_word(FUNC_PUT, 32'h0000_0001, 31'h0000_0001);
		send_word(FUNC_GET, 32'h8000_0000, '0);
		send_word(FUNC_GET, 32'h7fff_ffff, '0);
		send_word(FUNC_GET, 32'hffff_ffff, '0);
		send_word(FUNC_GET, 32'h0000_0001, '0);
		// overwrite a stored key
		send_word(FUNC_PUT, 32'h0000_0000, 31'h7fff_fffe);
		send_word(FUNC_GET, 32'h0000_0000, '0);
		// remove, remove again, then look it up
		send_word(FUNC_REMOVE, 32'h7fff_ffff, '0);
		send_word(FUNC_REMOVE, 32'h7fff_ffff, '0);
		send_word(FUNC_GET, 32'h7fff_ffff, '0);
		// new key lands in the freed entry
		send_word(FUNC_PUT, 32'h1234_5678, 31'h0765_4321);
		send_word(FUNC_GET, 32'h1234_5678, '0);
		send_word(FUNC_UNUSED, 32'h0000_0000, '1);
		send_word(FUNC_GET, 32'h0000_0000, '0);
		await_drain();

		while (sent < ITEM_TARGET) begin
			run_round();
			if ($urandom_range(0, 5) == 0)
				await_drain();
		end

		await_drain();
		repeat (ENTRIES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
